// ===== src/svm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the stack machine executor
// Opcode, command and status codes, state types and handshake structs.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned POOL_DEPTH_DEF  = 256;
  localparam logic [23:0] CNT_MAX         = 24'hFFFFFF;
  localparam logic [63:0] SIGN64          = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POW_NEG_ZERO    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_POOL_WR = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_HALT       = 5'd0,
    OP_NOP        = 5'd1,
    OP_PUSH_IMM   = 5'd2,
    OP_PUSH_0     = 5'd3,
    OP_PUSH_1     = 5'd4,
    OP_PUSH_2     = 5'd5,
    OP_PUSH_M1    = 5'd6,
    OP_PUSH_F0    = 5'd7,
    OP_PUSH_F1    = 5'd8,
    OP_PUSH_F2    = 5'd9,
    OP_PUSH_FHALF = 5'd10,
    OP_PUSH_FM1   = 5'd11,
    OP_POP        = 5'd12,
    OP_LOAD       = 5'd13,
    OP_ADD        = 5'd14,
    OP_SUB        = 5'd15,
    OP_MUL        = 5'd16,
    OP_POW        = 5'd17,
    OP_ADDW       = 5'd18,
    OP_SUBW       = 5'd19,
    OP_MULW       = 5'd20,
    OP_POWW       = 5'd21
  } opcode_e;

  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_HALT = 3'd1,
    ST_SOV  = 3'd2,
    ST_SUV  = 3'd3,
    ST_AOV  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_POOL_RD,
    S_STK_RD,
    S_ALU,
    S_DONE
  } ctl_state_e;

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_MUL,
    AL_PSTEP,
    AL_PWAIT
  } alu_state_e;

  typedef struct packed {
    logic       start;
    logic [4:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic ov;
  } alu_rsp_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } mul_rsp_t;

endpackage
`default_nettype wire

// ===== src/svm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svm_if: instruction and result channels
// Valid/ready channels that carry one instruction item or one result item.
// ----------------------------------------------------------------------------
interface svm_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [4:0]  opcode;
  logic        [23:0] immediate;
  logic signed [63:0] pool_word;

  modport source(output valid, output cmd, output opcode, output immediate,
                 output pool_word, input ready);
  modport sink(input valid, input cmd, input opcode, input immediate,
               input pool_word, output ready);
endinterface

interface svm_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [63:0] top_value;
  logic        [8:0]  stack_depth;
  logic        [23:0] instr_index;

  modport source(output valid, output status, output top_value,
                 output stack_depth, output instr_index, input ready);
  modport sink(input valid, input status, input top_value,
               input stack_depth, input instr_index, output ready);
endinterface
`default_nettype wire

// ===== src/svm_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svm_mul: multicycle signed 64x64 multiplier
// Four 32x32 partial products on magnitudes, with signed overflow detection.
// ----------------------------------------------------------------------------
module svm_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output svm_pkg::mul_rsp_t   rsp_o,
  output logic [63:0]         prod_o
);
  import svm_pkg::*;

  logic         busy_q, done_q;
  logic [2:0]   cnt_q;
  logic [63:0]  ua_q, ub_q, pp_q;
  logic [1:0]   sh_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [31:0]  op_a, op_b;
  logic [1:0]   sh_sel;
  logic [127:0] pp_ext;
  logic [63:0]  lim;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin op_a = ua_q[31:0];  op_b = ub_q[31:0];  sh_sel = 2'd0; end
      2'd1: begin op_a = ua_q[31:0];  op_b = ub_q[63:32]; sh_sel = 2'd1; end
      2'd2: begin op_a = ua_q[63:32]; op_b = ub_q[31:0];  sh_sel = 2'd1; end
      default: begin op_a = ua_q[63:32]; op_b = ub_q[63:32]; sh_sel = 2'd2; end
    endcase
    unique case (sh_q)
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
      default: pp_ext = {pp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[63] ? (64'd0 - a_i) : a_i;
      ub_q  <= b_i[63] ? (64'd0 - b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= op_a * op_b;
        sh_q <= sh_sel;
      end
      if (cnt_q != 3'd0) acc_q <= acc_q + pp_ext;
    end
  end

  assign lim        = neg_q ? SIGN64 : (SIGN64 - 64'd1);
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = (acc_q[127:64] != 64'd0) || (acc_q[63:0] > lim);
  assign prod_o     = neg_q ? (64'd0 - acc_q[63:0]) : acc_q[63:0];

endmodule
`default_nettype wire

// ===== src/svm_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svm_alu: binary operation unit
// Add and subtract in one step; multiply and power by squaring through the
// shared multicycle multiplier.
// ----------------------------------------------------------------------------
module svm_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svm_pkg::alu_req_t   req_i,
  input  logic [63:0]         a_i,
  input  logic [63:0]         b_i,
  output svm_pkg::alu_rsp_t   rsp_o,
  output logic [63:0]         res_o
);
  import svm_pkg::*;

  alu_state_e  st_q, st_d;
  logic        done_q, done_d, ov_q, ov_d, chk_q, chk_d;
  logic        have_y_q, have_y_d, sq_q, sq_d;
  logic [63:0] x_q, x_d, y_q, y_d, k_q, k_d, res_q, res_d;
  logic [63:0] ynew, sum, dif;
  logic        mul_start;
  logic [63:0] ma, mb, prod;
  mul_rsp_t    mul_rsp;
  logic        req_chk;

  svm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (ma),
    .b_i    (mb),
    .rsp_o  (mul_rsp),
    .prod_o (prod)
  );

  assign sum     = a_i + b_i;
  assign dif     = a_i - b_i;
  assign req_chk = (req_i.op <= OP_POW);
  assign ynew    = k_q[0] ? x_q : y_q;

  always_comb begin
    st_d      = st_q;
    done_d    = 1'b0;
    ov_d      = ov_q;
    res_d     = res_q;
    chk_d     = chk_q;
    x_d       = x_q;
    y_d       = y_q;
    k_d       = k_q;
    have_y_d  = have_y_q;
    sq_d      = sq_q;
    mul_start = 1'b0;
    ma        = x_q;
    mb        = x_q;
    unique case (st_q)
      AL_IDLE: begin
        if (req_i.start) begin
          chk_d = req_chk;
          ov_d  = 1'b0;
          unique case (req_i.op)
            OP_ADD, OP_ADDW: begin
              res_d  = sum;
              ov_d   = req_chk && (((a_i ^ sum) & (b_i ^ sum)) >> 63) != 64'd0;
              done_d = 1'b1;
            end
            OP_SUB, OP_SUBW: begin
              res_d  = dif;
              ov_d   = req_chk && (((a_i ^ b_i) & (a_i ^ dif)) >> 63) != 64'd0;
              done_d = 1'b1;
            end
            OP_MUL, OP_MULW: begin
              mul_start = 1'b1;
              ma        = a_i;
              mb        = b_i;
              st_d      = AL_MUL;
            end
            default: begin
              if (b_i == 64'd0) begin
                res_d  = 64'd1;
                done_d = 1'b1;
              end else if (b_i[63]) begin
                // Negative exponent: only the bases zero, one and minus one
                // give a nonzero result.
                if (a_i == 64'd0)          res_d = POW_NEG_ZERO;
                else if (a_i == 64'd1)     res_d = 64'd1;
                else if (a_i == '1)        res_d = b_i[0] ? '1 : 64'd1;
                else                       res_d = 64'd0;
                done_d = 1'b1;
              end else begin
                x_d      = a_i;
                k_d      = b_i;
                have_y_d = 1'b0;
                st_d     = AL_PSTEP;
              end
            end
          endcase
        end
      end
      AL_MUL: begin
        if (mul_rsp.done) begin
          res_d  = prod;
          ov_d   = chk_q && mul_rsp.ovf;
          done_d = 1'b1;
          st_d   = AL_IDLE;
        end
      end
      AL_PSTEP: begin
        if (k_q[0] && have_y_q) begin
          mul_start = 1'b1;
          ma        = y_q;
          mb        = x_q;
          sq_d      = 1'b0;
          st_d      = AL_PWAIT;
        end else begin
          y_d      = ynew;
          have_y_d = have_y_q | k_q[0];
          k_d      = k_q >> 1;
          if ((k_q >> 1) == 64'd0) begin
            res_d  = ynew;
            done_d = 1'b1;
            st_d   = AL_IDLE;
          end else begin
            mul_start = 1'b1;
            sq_d      = 1'b1;
            st_d      = AL_PWAIT;
          end
        end
      end
      default: begin
        if (mul_rsp.done) begin
          if (chk_q && mul_rsp.ovf) begin
            ov_d   = 1'b1;
            res_d  = 64'd0;
            done_d = 1'b1;
            st_d   = AL_IDLE;
          end else begin
            if (sq_q) begin
              x_d = prod;
            end else begin
              y_d = prod;
              k_d = {k_q[63:1], 1'b0};
            end
            st_d = AL_PSTEP;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AL_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ov_q     <= ov_d;
    res_q    <= res_d;
    chk_q    <= chk_d;
    x_q      <= x_d;
    y_q      <= y_d;
    k_q      <= k_d;
    have_y_q <= have_y_d;
    sq_q     <= sq_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ov   = ov_q;
  assign res_o      = res_q;

endmodule
`default_nettype wire

// ===== src/stack_vm_integer_executor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_vm_integer_executor: 64-bit stack machine, one instruction per item
// Stack and constant pool in synchronous memories, sequenced by a controller.
// ----------------------------------------------------------------------------
// Pushes, halt, nop, restart, pool writes and a pop to empty go from decode
// to done; pool loads add a pool read, other pops a stack read, add/sub a
// stack read and the binary unit; multiply also waits on the multiplier,
// which power uses once per squaring or multiply, up to about 126 of them.
// A non power-of-two pool adds an index reduction state per pool access.
// One item in work at a time. Reset clears controller, depth, status, counter.
// ----------------------------------------------------------------------------
module stack_vm_integer_executor #(
  parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned POOL_DEPTH  = svm_pkg::POOL_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svm_in_if.sink    in_i,
  svm_out_if.source out_o
);
  import svm_pkg::*;

  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam bit POOL_POW2 = (POOL_DEPTH > 1) &&
                             ((POOL_DEPTH & (POOL_DEPTH - 1)) == 0);
  // Reciprocal of the pool size, exact for every 24-bit index.
  localparam int unsigned RSH = 24 + PAW;
  localparam logic [63:0] RCP = ((64'd1 << RSH) + 64'(POOL_DEPTH) - 64'd1) /
                                64'(POOL_DEPTH);
  // Bit patterns of the double constants.
  localparam logic [63:0] F64_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] F64_TWO  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] F64_HALF = 64'h3FE0_0000_0000_0000;
  localparam logic [63:0] F64_M1   = 64'hBFF0_0000_0000_0000;

  // Controller state and latched item.
  ctl_state_e  state_q, state_d;
  logic [1:0]  cmd_q;
  logic [4:0]  op_q;
  logic [23:0] imm_q;
  logic [63:0] word_q;

  // Architectural state. The top record is also kept in a register so that
  // the result can show it without a memory read.
  logic [DW-1:0] depth_q, depth_d, dm2;
  logic [63:0]   top_q, top_d;
  status_e       stop_q, stop_d;
  logic [23:0]   cnt_q, cnt_d;
  logic          full;

  // Pool index reduction: the quotient is registered, the remainder follows.
  logic [PAW-1:0] pidx;
  logic [23:0]    quo_q, quo_d, quo_n, prem;
  logic [49:0]    rcp_prod;
  logic [48:0]    quo_prod;

  // Memory ports.
  logic [63:0]    stk_mem [STACK_DEPTH];
  logic [63:0]    pool_mem [POOL_DEPTH];
  logic           stk_we, stk_re, pool_we, pool_re;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [PAW-1:0] pool_addr;
  logic [63:0]    stk_wdata, stk_rdata_q, pool_rdata_q;

  // Push request merged from several states.
  logic        do_push;
  logic [63:0] push_v;

  // Binary unit.
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [63:0] alu_res;

  // Output register.
  logic        ov_q, slot_free;
  logic [2:0]  o_status_q;
  logic [63:0] o_top_q;
  logic [8:0]  o_depth_q;
  logic [23:0] o_index_q;

  svm_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (stk_rdata_q),
    .b_i   (top_q),
    .rsp_o (alu_rsp),
    .res_o (alu_res)
  );

  assign full      = (depth_q == DW'(STACK_DEPTH));
  assign dm2       = depth_q - DW'(2);
  assign rcp_prod  = {26'd0, imm_q} * {24'd0, RCP[25:0]};
  assign quo_n     = 24'(rcp_prod >> RSH);
  assign quo_prod  = {25'd0, quo_q} * {24'd0, 25'(POOL_DEPTH)};
  assign prem      = imm_q - quo_prod[23:0];
  assign pidx      = (state_q == S_MOD) ? prem[PAW-1:0] : imm_q[PAW-1:0];
  assign slot_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    depth_d   = depth_q;
    top_d     = top_q;
    stop_d    = stop_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = depth_q[SAW-1:0];
    stk_raddr = dm2[SAW-1:0];
    stk_wdata = 64'd0;
    pool_we   = 1'b0;
    pool_re   = 1'b0;
    pool_addr = pidx;
    do_push   = 1'b0;
    push_v    = 64'd0;
    alu_req   = '{start: 1'b0, op: op_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (cmd_q)
          CMD_EXEC: begin
            if (stop_q == ST_RUN) begin
              if (cnt_q != CNT_MAX) cnt_d = cnt_q + 24'd1;
              unique case (op_q)
                OP_HALT:       stop_d = ST_HALT;
                OP_PUSH_IMM: begin
                  do_push = 1'b1;
                  push_v  = {{40{imm_q[23]}}, imm_q};
                end
                OP_PUSH_0, OP_PUSH_F0: do_push = 1'b1;
                OP_PUSH_1:     begin do_push = 1'b1; push_v = 64'd1;    end
                OP_PUSH_2:     begin do_push = 1'b1; push_v = 64'd2;    end
                OP_PUSH_M1:    begin do_push = 1'b1; push_v = '1;       end
                OP_PUSH_F1:    begin do_push = 1'b1; push_v = F64_ONE;  end
                OP_PUSH_F2:    begin do_push = 1'b1; push_v = F64_TWO;  end
                OP_PUSH_FHALF: begin do_push = 1'b1; push_v = F64_HALF; end
                OP_PUSH_FM1:   begin do_push = 1'b1; push_v = F64_M1;   end
                OP_POP: begin
                  if (depth_q == '0) begin
                    stop_d = ST_SUV;
                  end else begin
                    depth_d = depth_q - DW'(1);
                    // The record below becomes the new top.
                    if (depth_q >= DW'(2)) begin
                      stk_re  = 1'b1;
                      state_d = S_STK_RD;
                    end
                  end
                end
                OP_LOAD: begin
                  if (full) begin
                    stop_d = ST_SOV;
                  end else if (POOL_POW2) begin
                    pool_re = 1'b1;
                    state_d = S_POOL_RD;
                  end else begin
                    quo_d   = quo_n;
                    state_d = S_MOD;
                  end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_POW,
                OP_ADDW, OP_SUBW, OP_MULW, OP_POWW: begin
                  if (depth_q < DW'(2)) begin
                    stop_d = ST_SUV;
                  end else begin
                    stk_re  = 1'b1;
                    state_d = S_STK_RD;
                  end
                end
                default: ;
              endcase
            end
          end
          CMD_POOL_WR: begin
            if (POOL_POW2) begin
              pool_we = 1'b1;
            end else begin
              quo_d   = quo_n;
              state_d = S_MOD;
            end
          end
          CMD_RESTART: begin
            depth_d = '0;
            stop_d  = ST_RUN;
            cnt_d   = '0;
          end
          default: ;
        endcase
      end
      S_MOD: begin
        if (cmd_q == CMD_POOL_WR) begin
          pool_we = 1'b1;
          state_d = S_DONE;
        end else begin
          pool_re = 1'b1;
          state_d = S_POOL_RD;
        end
      end
      S_POOL_RD: begin
        do_push = 1'b1;
        push_v  = pool_rdata_q;
        state_d = S_DONE;
      end
      S_STK_RD: begin
        if (op_q == OP_POP) begin
          top_d   = stk_rdata_q;
          state_d = S_DONE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          state_d = S_DONE;
          if (alu_rsp.ov) begin
            stop_d = ST_AOV;
          end else begin
            // Result replaces the two operands.
            stk_we    = 1'b1;
            stk_waddr = dm2[SAW-1:0];
            stk_wdata = alu_res;
            top_d     = alu_res;
            depth_d   = depth_q - DW'(1);
          end
        end
      end
      default: begin
        if (slot_free) state_d = S_IDLE;
      end
    endcase

    if (do_push) begin
      if (full) begin
        stop_d = ST_SOV;
      end else begin
        stk_we    = 1'b1;
        stk_waddr = depth_q[SAW-1:0];
        stk_wdata = push_v;
        top_d     = push_v;
        depth_d   = depth_q + DW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      stop_q  <= ST_RUN;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      stop_q  <= stop_d;
      cnt_q   <= cnt_d;
      if (state_q == S_DONE && slot_free) ov_q <= 1'b1;
      else if (out_o.ready)               ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    quo_q <= quo_d;
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.cmd;
      op_q   <= in_i.opcode;
      imm_q  <= in_i.immediate;
      word_q <= in_i.pool_word;
    end
    if (state_q == S_DONE && slot_free) begin
      o_status_q <= stop_q;
      o_top_q    <= (depth_q != '0) ? top_q : 64'd0;
      o_depth_q  <= 9'(depth_q);
      o_index_q  <= cnt_q;
    end
  end

  // Stack memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  // Constant pool: single port, write or registered read.
  always_ff @(posedge clk_i) begin
    if (pool_we) pool_mem[pool_addr] <= word_q;
    if (pool_re) pool_rdata_q <= pool_mem[pool_addr];
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = o_status_q;
  assign out_o.top_value   = o_top_q;
  assign out_o.stack_depth = o_depth_q;
  assign out_o.instr_index = o_index_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth above capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted transfer not decoded");

  a_alu_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALU && alu_rsp.done && !alu_rsp.ov) |=>
      (depth_q == $past(depth_q) - DW'(1)))
    else $error("binary result did not drop one record");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_MAX) |=> (cnt_q == CNT_MAX || cnt_q == '0))
    else $error("instruction counter wrapped");

endmodule
`default_nettype wire

// ===== bench/tb_stack_vm_integer_executor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_stack_vm_integer_executor: self-checking bench for the stack executor
// Feeds directed and random instruction streams through the valid/ready
// channels, predicts every result with a behavioral machine and compares.
// ----------------------------------------------------------------------------
module tb_stack_vm_integer_executor;
  import svm_pkg::*;

  localparam int unsigned NSTK       = 256;
  localparam int unsigned NPOOL      = 256;
  localparam int unsigned CYCLE_CAP  = 4_000_000;
  localparam int unsigned DRAIN_WAIT = 1200;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  op;
    logic [23:0] imm;
    logic [63:0] word;
  } instr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] top;
    logic [8:0]  depth;
    logic [23:0] idx;
  } machine_view_t;

  logic clk_i;
  logic rst_ni;

  svm_in_if  in_ch();
  svm_out_if out_ch();

  stack_vm_integer_executor dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Clock with a period of 8 units.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the machine. It advances once per accepted input
  // transfer and appends the view the block must report to view_q.
  // --------------------------------------------------------------------------
  logic [63:0]   stk_mem [NSTK];
  logic [63:0]   pool_mem[NPOOL];
  int unsigned   mach_depth;
  status_e       mach_status;
  logic [23:0]   mach_count;
  machine_view_t view_q[$];
  int unsigned   status_seen[8];

  // Signed multiply on bit patterns; ov flags a result outside 64 bits.
  function automatic logic [63:0] smul_checked(input logic [63:0] a, input logic [63:0] b,
                                               output logic ov);
    logic          neg;
    logic [63:0]   ua, ub, lim;
    logic [127:0]  p;
    neg = a[63] ^ b[63];
    ua  = a[63] ? -a : a;
    ub  = b[63] ? -b : b;
    lim = neg ? SIGN64 : SIGN64 - 64'd1;
    p   = {64'd0, ua} * {64'd0, ub};
    ov  = (p[127:64] != 64'd0) || (p[63:0] > lim);
    return a * b;
  endfunction

  function automatic logic [63:0] mul_step(input logic [63:0] a, input logic [63:0] b,
                                           input logic checked, inout logic ov);
    logic o;
    logic [63:0] r;
    r = smul_checked(a, b, o);
    if (checked && o) ov = 1'b1;
    return r;
  endfunction

  // Exponentiation by squaring, with the negative-exponent rules.
  function automatic logic [63:0] raise(input logic [63:0] base, input logic [63:0] e,
                                        input logic checked, output logic ov);
    logic [63:0] x, k, y;
    ov = 1'b0;
    x  = base;
    k  = e;
    if (k == 64'd0) return 64'd1;
    if (k[63]) begin
      if (x == 64'd0) return POW_NEG_ZERO;
      if (x == 64'd1) return 64'd1;
      if (x == '1) return k[0] ? '1 : 64'd1;
      return 64'd0;
    end
    while (!k[0]) begin
      x = mul_step(x, x, checked, ov);
      if (ov) return 64'd0;
      k = k >> 1;
    end
    y = x;
    k = k >> 1;
    if (k != 64'd0) begin
      while (1) begin
        x = mul_step(x, x, checked, ov);
        if (ov) return 64'd0;
        if (k == 64'd1) break;
        if (k[0]) begin
          y = mul_step(y, x, checked, ov);
          if (ov) return 64'd0;
        end
        k = k >> 1;
      end
      y = mul_step(y, x, checked, ov);
      if (ov) return 64'd0;
    end
    return y;
  endfunction

  function automatic void push_record(input logic [63:0] v);
    if (mach_depth >= NSTK) begin
      mach_status = ST_SOV;
    end else begin
      stk_mem[mach_depth] = v;
      mach_depth++;
    end
  endfunction

  function automatic void binary_op(input opcode_e op);
    logic [63:0] a, b, r;
    logic        ov;
    ov = 1'b0;
    r  = 64'd0;
    if (mach_depth < 2) begin
      mach_status = ST_SUV;
      return;
    end
    a = stk_mem[mach_depth-2];
    b = stk_mem[mach_depth-1];
    case (op)
      OP_ADD: begin
        r  = a + b;
        ov = (((a ^ r) & (b ^ r)) >> 63) != 64'd0;
      end
      OP_SUB: begin
        r  = a - b;
        ov = (((a ^ b) & (a ^ r)) >> 63) != 64'd0;
      end
      OP_MUL:  r = smul_checked(a, b, ov);
      OP_POW:  r = raise(a, b, 1'b1, ov);
      OP_ADDW: r = a + b;
      OP_SUBW: r = a - b;
      OP_MULW: r = a * b;
      default: r = raise(a, b, 1'b0, ov);
    endcase
    if (ov) begin
      mach_status = ST_AOV;
      return;
    end
    stk_mem[mach_depth-2] = r;
    mach_depth--;
  endfunction

  function automatic void run_instr(input logic [4:0] op, input logic [23:0] imm);
    case (op)
      OP_HALT:       mach_status = ST_HALT;
      OP_PUSH_IMM:   push_record({{40{imm[23]}}, imm});
      OP_PUSH_0:     push_record(64'd0);
      OP_PUSH_1:     push_record(64'd1);
      OP_PUSH_2:     push_record(64'd2);
      OP_PUSH_M1:    push_record('1);
      OP_PUSH_F0:    push_record(64'd0);
      OP_PUSH_F1:    push_record(64'h3FF0_0000_0000_0000);
      OP_PUSH_F2:    push_record(64'h4000_0000_0000_0000);
      OP_PUSH_FHALF: push_record(64'h3FE0_0000_0000_0000);
      OP_PUSH_FM1:   push_record(64'hBFF0_0000_0000_0000);
      OP_POP: begin
        if (mach_depth == 0) mach_status = ST_SUV;
        else mach_depth--;
      end
      OP_LOAD: push_record(pool_mem[imm % NPOOL]);
      OP_ADD, OP_SUB, OP_MUL, OP_POW, OP_ADDW, OP_SUBW, OP_MULW, OP_POWW:
        binary_op(opcode_e'(op));
      default: ;
    endcase
  endfunction

  // Advances the machine by one item and records the view it must show.
  function automatic void machine_step(input instr_t it);
    machine_view_t v;
    case (it.cmd)
      CMD_EXEC: begin
        if (mach_status == ST_RUN) begin
          if (mach_count != CNT_MAX) mach_count++;
          run_instr(it.op, it.imm);
        end
      end
      CMD_POOL_WR: pool_mem[it.imm % NPOOL] = it.word;
      CMD_RESTART: begin
        mach_depth  = 0;
        mach_status = ST_RUN;
        mach_count  = '0;
      end
      default: ;
    endcase
    v.status = mach_status;
    v.top    = (mach_depth > 0) ? stk_mem[mach_depth-1] : 64'd0;
    v.depth  = mach_depth[8:0];
    v.idx    = mach_count;
    view_q.push_back(v);
  endfunction

  // --------------------------------------------------------------------------
  // Program generation. The generator keeps its own record of which pool
  // entries were written, so that a load never reads an unwritten entry.
  // --------------------------------------------------------------------------
  instr_t      prog_q[$];
  bit          pool_known[NPOOL];
  int unsigned known_list[$];

  function automatic void emit(input cmd_e c, input logic [4:0] op,
                               input logic [23:0] imm, input logic [63:0] w);
    instr_t it;
    it.cmd  = c;
    it.op   = op;
    it.imm  = imm;
    it.word = w;
    prog_q.push_back(it);
    if (c == CMD_POOL_WR && !pool_known[imm % NPOOL]) begin
      pool_known[imm % NPOOL] = 1'b1;
      known_list.push_back(imm % NPOOL);
    end
  endfunction

  function automatic void exec(input opcode_e op, input logic [23:0] imm = '0);
    emit(CMD_EXEC, op, imm, {$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return 64'($signed($urandom_range(0, 8)) - 4);
      2:       return SIGN64 ^ 64'($urandom_range(0, 2));
      3:       return POW_NEG_ZERO - 64'($urandom_range(0, 2));
      4:       return 64'($urandom_range(0, 70000));
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  // Pushes one random operand through one of the push forms.
  function automatic void push_any();
    int unsigned i;
    case ($urandom_range(0, 4))
      0, 1: exec(OP_PUSH_IMM, 24'($urandom));
      2: begin
        if (known_list.size() > 0) begin
          i = known_list[$urandom_range(0, known_list.size() - 1)];
          exec(OP_LOAD, 24'(i + NPOOL * $urandom_range(0, 65535)));
        end else begin
          exec(OP_PUSH_2);
        end
      end
      3: exec(opcode_e'($urandom_range(OP_PUSH_0, OP_PUSH_FM1)));
      default: exec(OP_PUSH_IMM, 24'($signed($urandom_range(0, 8)) - 4));
    endcase
  endfunction

  // A restart followed by a short, mostly well-formed program.
  function automatic void random_program();
    int unsigned n, live;
    emit(CMD_RESTART, 5'($urandom), 24'($urandom), {$urandom, $urandom});
    n    = $urandom_range(2, 10);
    live = 0;
    for (int unsigned j = 0; j < n; j++) begin
      if ($urandom_range(0, 3) == 0) begin
        emit(CMD_POOL_WR, 5'($urandom), 24'($urandom), rand_word());
      end else if (live < 2 || $urandom_range(0, 2) == 0) begin
        push_any();
        live++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          // Power with a small base and an exponent that stays cheap mostly.
          exec(OP_PUSH_IMM, 24'($signed($urandom_range(0, 10)) - 5));
          exec(OP_PUSH_IMM, ($urandom_range(0, 5) == 0) ? 24'($urandom)
                                                         : 24'($urandom_range(0, 70)));
          exec($urandom_range(0, 1) ? OP_POW : OP_POWW);
        end else begin
          exec(opcode_e'($urandom_range(OP_ADD, OP_POWW)));
          live--;
        end
      end
    end
    // Noise: pops, halts, unused codes, binary ops and the spare command.
    case ($urandom_range(0, 7))
      0: exec(OP_POP);
      1: exec(OP_HALT);
      2: emit(CMD_EXEC, 5'($urandom_range(22, 31)), 24'($urandom), '0);
      3: emit(CMD_SPARE, 5'($urandom), 24'($urandom), {$urandom, $urandom});
      4: exec(opcode_e'($urandom_range(OP_ADD, OP_POWW)));
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one item on the channel at a time, a random gap between
  // items, with back-to-back stretches where the gap is zero.
  // --------------------------------------------------------------------------
  int unsigned in_gap;
  int unsigned n_sent;
  logic        drv_busy;
  instr_t      drv_cur;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        machine_step(drv_cur);
        n_sent++;
        drv_busy = 1'b0;
        in_gap   = ((n_sent / 150) % 3 == 0) ? 0 : $urandom_range(0, 6);
      end
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (prog_q.size() > 0) begin
          drv_cur           = prog_q.pop_front();
          in_ch.cmd        <= drv_cur.cmd;
          in_ch.opcode     <= drv_cur.op;
          in_ch.immediate  <= drv_cur.imm;
          in_ch.pool_word  <= drv_cur.word;
          drv_busy          = 1'b1;
        end
      end
      in_ch.valid <= drv_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off on the result side. It starts once, mid-run, and lasts
  // long enough for the block to back up and stall its input.
  // --------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_done;
  logic        out_hold;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_sent >= 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_hold <= (hold_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares each result transfer with the oldest view.
  // --------------------------------------------------------------------------
  int unsigned   out_stall;
  int unsigned   n_checked;
  int unsigned   n_bad;
  machine_view_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (view_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("ERROR: result with nothing expected: %s %0d top %h depth %0d idx %0d",
                     "status", out_ch.status, out_ch.top_value, out_ch.stack_depth,
                     out_ch.instr_index);
        end else begin
          want = view_q.pop_front();
          status_seen[want.status]++;
          if (out_ch.status !== want.status || out_ch.top_value !== want.top ||
              out_ch.stack_depth !== want.depth || out_ch.instr_index !== want.idx) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("ERROR: result %0d mismatch", n_checked);
              $display("  expected status %0d top %h depth %0d idx %0d",
                       want.status, want.top, want.depth, want.idx);
              $display("  actual   status %0d top %h depth %0d idx %0d",
                       out_ch.status, out_ch.top_value, out_ch.stack_depth,
                       out_ch.instr_index);
            end
          end
        end
        out_stall = ((n_checked / 200) % 3 == 1) ? 0 : $urandom_range(0, 6);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ch.ready <= (out_stall == 0) && !out_hold;
    end
  end

  // Run-length guard.
  int unsigned cyc;
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    bit filled;
    filled          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = '0;
    in_ch.opcode    = '0;
    in_ch.immediate = '0;
    in_ch.pool_word = '0;
    out_ch.ready    = 1'b0;
    out_hold        = 1'b0;
    rst_ni          = 1'b0;
    mach_depth      = 0;
    mach_status     = ST_RUN;
    mach_count      = '0;

    // Directed part: pool extremes, index wrap, every push form, overflow,
    // underflow, halt, stopped-machine behavior, power special bases.
    emit(CMD_POOL_WR, '0, 24'd0, POW_NEG_ZERO);
    emit(CMD_POOL_WR, '0, 24'hFFFFFF, SIGN64);
    exec(OP_LOAD, 24'd0);
    exec(OP_PUSH_1);
    exec(OP_ADD);                        // checked add overflows, stack kept
    exec(OP_NOP);                        // ignored while stopped
    emit(CMD_POOL_WR, '0, 24'd256, 64'hFFFF_FFFF_FFFF_FFFF);
    emit(CMD_RESTART, '0, '0, '0);
    exec(OP_POP);                        // pop on an empty stack
    emit(CMD_RESTART, '0, '0, '0);
    exec(OP_PUSH_IMM, 24'h7FFFFF);
    exec(OP_SUB);                        // binary op with one record
    emit(CMD_RESTART, '0, '0, '0);
    for (int op = OP_PUSH_0; op <= OP_PUSH_FM1; op++) exec(opcode_e'(op));
    exec(OP_PUSH_IMM, 24'h800000);
    exec(OP_LOAD, 24'h0000FF);
    exec(OP_MULW);
    exec(OP_PUSH_0);
    exec(OP_PUSH_M1);
    exec(OP_POW);                        // zero to a negative power
    emit(CMD_EXEC, 5'd31, 24'hFFFFFF, '0);
    emit(CMD_SPARE, 5'd31, 24'hFFFFFF, '1);
    exec(OP_HALT);

    // Random part: one complete stack fill to overflow, the rest short
    // programs with random content.
    while (prog_q.size() + n_sent < 1200) begin
      if (!filled && prog_q.size() > 500) begin
        filled = 1'b1;
        emit(CMD_RESTART, '0, '0, '0);
        for (int unsigned j = 0; j <= NSTK; j++) push_any();
        exec(OP_MULW);
        exec(OP_SUBW);
      end
      random_program();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (prog_q.size() == 0 && !in_ch.valid && view_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (view_q.size() != 0) n_bad += view_q.size();

    $display("Run covered %0d input transfers and %0d checked results.", n_sent, n_checked);
    $display("Final states seen: running %0d, halted %0d, stack overflow %0d,",
             status_seen[ST_RUN], status_seen[ST_HALT], status_seen[ST_SOV]);
    $display("  underflow %0d, arith overflow %0d.",
             status_seen[ST_SUV], status_seen[ST_AOV]);
    if (n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
